@@ rtl/pcc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcc_pkg: shared constants, types and helpers for the pair counter
// Sizes of the species set and counters, pair index mapping, saturation.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int MAX_SPECIES = 8;
  localparam int COUNT_BITS  = 16;
  localparam int NUM_PAIRS   = (MAX_SPECIES * (MAX_SPECIES - 1)) / 2;
  localparam int PAIR_BITS   = $clog2(NUM_PAIRS);
  localparam int SPEC_BITS   = $clog2(MAX_SPECIES + 1);

  localparam int ROW_BITS    = 8;
  localparam int FIELD_BITS  = 16;
  localparam int IDX_BITS    = 4;
  localparam int CFG_BITS    = 4;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd8;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef logic [COUNT_BITS-1:0] cnt_t;
  typedef logic [SPEC_BITS-1:0]  spec_t;
  typedef logic [PAIR_BITS-1:0]  pair_idx_t;

  localparam cnt_t CNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic                last;
  } site_t;

  typedef struct packed {
    logic emitting;
    logic clearing;
  } status_t;

  // First species (0-based) of pair k in row-major order
  function automatic int pair_first(int k);
    int idx;
    int res;
    idx = 0;
    res = 0;
    for (int i = 0; i < MAX_SPECIES - 1; i++) begin
      for (int j = i + 1; j < MAX_SPECIES; j++) begin
        if (idx == k) res = i;
        idx++;
      end
    end
    return res;
  endfunction

  // Second species (0-based) of pair k in row-major order
  function automatic int pair_second(int k);
    int idx;
    int res;
    idx = 0;
    res = 0;
    for (int i = 0; i < MAX_SPECIES - 1; i++) begin
      for (int j = i + 1; j < MAX_SPECIES; j++) begin
        if (idx == k) res = j;
        idx++;
      end
    end
    return res;
  endfunction

  // Presence of species s; bits past the row width read as absent
  function automatic logic present(logic [ROW_BITS-1:0] row, int s);
    logic [ROW_BITS-1:0] sh;
    sh = row >> s;
    return (s < ROW_BITS) && sh[0];
  endfunction

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == CNT_MAX) ? v : v + cnt_t'(1);
  endfunction

  function automatic cnt_t sat_add(cnt_t a, cnt_t b);
    logic [COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_BITS] ? CNT_MAX : s[COUNT_BITS-1:0];
  endfunction

  function automatic logic [FIELD_BITS-1:0] to_field(cnt_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[FIELD_BITS-1:0];
  endfunction

  // Clamp the species register into [2, MAX_SPECIES]
  function automatic spec_t clamp_species(logic [CFG_BITS-1:0] v);
    if (v < CFG_BITS'(2)) return spec_t'(2);
    else if (32'(v) > MAX_SPECIES) return spec_t'(MAX_SPECIES);
    else return spec_t'(v);
  endfunction

endpackage

@@ rtl/pcc_ifs.sv @@
// ----------------------------------------------------------------------------
// pcc_ifs: channel interfaces of the pair counter
// Site channel in, pair result channel out; valid/ready with payload.
// ----------------------------------------------------------------------------
interface pcc_site_if;
  logic       valid;
  logic       ready;
  logic [7:0] presence_row;
  logic       last_site;

  modport source (output valid, output presence_row, output last_site, input ready);
  modport sink   (input valid, input presence_row, input last_site, output ready);
endinterface

interface pcc_pair_if;
  logic        valid;
  logic        ready;
  logic [3:0]  first_species;
  logic [3:0]  second_species;
  logic [15:0] count_first_only;
  logic [15:0] count_second_only;
  logic [15:0] count_both;
  logic [15:0] count_neither;
  logic [15:0] total_first;
  logic [15:0] total_second;
  logic        last_pair;

  modport source (
    output valid, output first_species, output second_species,
    output count_first_only, output count_second_only, output count_both,
    output count_neither, output total_first, output total_second,
    output last_pair, input ready
  );
  modport sink (
    input valid, input first_species, input second_species,
    input count_first_only, input count_second_only, input count_both,
    input count_neither, input total_first, input total_second,
    input last_pair, output ready
  );
endinterface

@@ rtl/pairwise_cooccurrence_counts.sv @@
// ----------------------------------------------------------------------------
// pairwise_cooccurrence_counts: pairwise presence/absence contingency counts
// Throughput: one site per cycle while the queue has room; the counter
//   engine takes no sites while it emits the P = n(n-1)/2 pairs in use,
//   one result per cycle while the sink is ready. A last site passes the
//   queue, the counter update, then the output register before its results.
// Reset: synchronous; counters zero, queue empty, species in use = 8.
// ----------------------------------------------------------------------------
module pairwise_cooccurrence_counts
  import pcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  pcc_site_if.sink            sites,
  pcc_pair_if.source          pairs
);

  logic [CFG_BITS-1:0] species_cfg;
  logic                q_valid;
  logic                q_ready;
  site_t               q_data;
  status_t             stat;

  // Hold the species-in-use register
  always_ff @(posedge clk) begin
    if (rst) begin
      species_cfg <= CFG_RESET;
    end else if (cfg_we) begin
      species_cfg <= cfg_wdata;
    end
  end

  pcc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .sites   (sites),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_data  (q_data)
  );

  pcc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .species_cfg (species_cfg),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_data      (q_data),
    .pairs       (pairs),
    .stat        (stat)
  );

`ifndef ASSERT_OFF
  // Pair indices stay ordered and in range
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    pairs.valid |-> (pairs.first_species != 4'd0) &&
                    (pairs.first_species < pairs.second_species) &&
                    (32'(pairs.second_species) <= MAX_SPECIES))
    else $error("pair indices out of order or range");

  // Within a data set the next pair follows any non-final transfer
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (pairs.valid && pairs.ready && !pairs.last_pair) |=> pairs.valid)
    else $error("gap inside a pair burst");

  // Clearing coincides with loading the final pair
  a_clear_last: assert property (@(posedge clk) disable iff (rst)
    stat.clearing |=> (pairs.valid && pairs.last_pair))
    else $error("counters cleared without final pair");

  // No site is pulled from the queue during emission
  a_no_pop_emit: assert property (@(posedge clk) disable iff (rst)
    stat.emitting |-> !(q_valid && q_ready))
    else $error("site consumed during emission");
`endif

endmodule

@@ rtl/pcc_front.sv @@
// ----------------------------------------------------------------------------
// pcc_front: site intake and queue
// Takes site rows from the input channel and holds them in a short FIFO
// until the counter engine pulls them.
// ----------------------------------------------------------------------------
module pcc_front
  import pcc_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  pcc_site_if.sink sites,
  output logic   q_valid,
  input  logic   q_ready,
  output site_t  q_data
);

  site_t                mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 push;
  logic                 pop;

  assign sites.ready = (count != (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign push        = sites.valid && sites.ready;
  assign q_valid     = (count != '0);
  assign pop         = q_valid && q_ready;
  assign q_data      = mem[rd_ptr];

  // Store each transfer at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{row: sites.presence_row, last: sites.last_site};
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_BITS'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_BITS'(1);
      if (push && !pop)      count <= count + (QPTR_BITS+1)'(1);
      else if (pop && !push) count <= count - (QPTR_BITS+1)'(1);
    end
  end

endmodule

@@ rtl/pcc_back.sv @@
// ----------------------------------------------------------------------------
// pcc_back: pair counter engine and result sequencer
// Updates every pair's contingency counters for each site, then walks the
// pairs in use into the output register, one per unstalled cycle; clears.
// ----------------------------------------------------------------------------
module pcc_back
  import pcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [CFG_BITS-1:0] species_cfg,
  input  logic                q_valid,
  output logic                q_ready,
  input  site_t               q_data,
  pcc_pair_if.source          pairs,
  output status_t             stat
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  cnt_t both_cnt   [NUM_PAIRS];
  cnt_t first_cnt  [NUM_PAIRS];
  cnt_t second_cnt [NUM_PAIRS];
  cnt_t neither_cnt[NUM_PAIRS];

  logic      st;
  pair_idx_t k;
  spec_t     fi;
  spec_t     se;
  spec_t     n_lat;

  logic pop;
  logic load;
  logic emit_load;
  logic row_end;
  logic last_now;
  cnt_t sel_both;
  cnt_t sel_first;
  cnt_t sel_second;
  cnt_t sel_neither;

  assign q_ready   = (st == ST_IDLE);
  assign pop       = q_valid && q_ready;
  assign load      = !pairs.valid || pairs.ready;
  assign emit_load = load && (st == ST_EMIT);
  assign row_end   = (se == n_lat - spec_t'(1));
  assign last_now  = row_end && (fi == n_lat - spec_t'(2));

  assign sel_both    = both_cnt[k];
  assign sel_first   = first_cnt[k];
  assign sel_second  = second_cnt[k];
  assign sel_neither = neither_cnt[k];

  assign stat.emitting = (st == ST_EMIT);
  assign stat.clearing = emit_load && last_now;

  // Count each site into all pairs at once; clear after the last pair
  always_ff @(posedge clk) begin : upd
    logic pi;
    logic pj;
    if (rst || (emit_load && last_now)) begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
        both_cnt[p]    <= '0;
        first_cnt[p]   <= '0;
        second_cnt[p]  <= '0;
        neither_cnt[p] <= '0;
      end
    end else if (pop) begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
        pi = present(q_data.row, pair_first(p));
        pj = present(q_data.row, pair_second(p));
        if (pi && pj)  both_cnt[p]    <= sat_inc(both_cnt[p]);
        else if (pi)   first_cnt[p]   <= sat_inc(first_cnt[p]);
        else if (pj)   second_cnt[p]  <= sat_inc(second_cnt[p]);
        else           neither_cnt[p] <= sat_inc(neither_cnt[p]);
      end
    end
  end

  // Sequence through the pairs in use, skipping unused columns
  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= ST_IDLE;
      k     <= '0;
      fi    <= '0;
      se    <= spec_t'(1);
      n_lat <= spec_t'(2);
    end else begin
      case (st)
        ST_IDLE: begin
          if (pop && q_data.last) begin
            st    <= ST_EMIT;
            k     <= '0;
            fi    <= '0;
            se    <= spec_t'(1);
            n_lat <= clamp_species(species_cfg);
          end
        end
        ST_EMIT: begin
          if (emit_load) begin
            if (last_now) begin
              st <= ST_IDLE;
            end else if (row_end) begin
              fi <= fi + spec_t'(1);
              se <= fi + spec_t'(2);
              k  <= pair_idx_t'(32'(k) + 1 + MAX_SPECIES - 32'(n_lat));
            end else begin
              se <= se + spec_t'(1);
              k  <= k + pair_idx_t'(1);
            end
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // Output register valid: hold until transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      pairs.valid <= 1'b0;
    end else if (load) begin
      pairs.valid <= (st == ST_EMIT);
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (emit_load) begin
      pairs.first_species     <= IDX_BITS'(fi) + IDX_BITS'(1);
      pairs.second_species    <= IDX_BITS'(se) + IDX_BITS'(1);
      pairs.count_first_only  <= to_field(sel_first);
      pairs.count_second_only <= to_field(sel_second);
      pairs.count_both        <= to_field(sel_both);
      pairs.count_neither     <= to_field(sel_neither);
      pairs.total_first       <= to_field(sat_add(sel_both, sel_first));
      pairs.total_second      <= to_field(sat_add(sel_both, sel_second));
      pairs.last_pair         <= last_now;
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for pairwise_cooccurrence_counts
// Sends presence rows grouped into data sets under several species settings.
// Keeps its own contingency tallies per species pair and checks every pair
// result, field by field, in order. Both channels idle and stall at random.
// Includes a long result hold-off while full data sets keep arriving.
// ----------------------------------------------------------------------------
module testbench
  import pcc_pkg::*;
();

  typedef struct packed {
    logic [3:0]  first_species;
    logic [3:0]  second_species;
    logic [15:0] count_first_only;
    logic [15:0] count_second_only;
    logic [15:0] count_both;
    logic [15:0] count_neither;
    logic [15:0] total_first;
    logic [15:0] total_second;
    logic        last_pair;
  } pair_counts_t;

  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES   = 400;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_wdata;

  pcc_site_if site_ch();
  pcc_pair_if pair_ch();

  pairwise_cooccurrence_counts uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sites     (site_ch),
    .pairs     (pair_ch)
  );

  // Tallies of the current data set, one entry per species pair
  logic [15:0] both_seen        [NUM_PAIRS];
  logic [15:0] first_only_seen  [NUM_PAIRS];
  logic [15:0] second_only_seen [NUM_PAIRS];
  logic [15:0] neither_seen     [NUM_PAIRS];
  logic [CFG_BITS-1:0] species_cfg;

  site_t        sites_to_send [$];
  pair_counts_t pending_pairs [$];

  int   fail_count = 0;
  int   send_gap_max = 0;
  int   recv_stall_max = 0;
  logic hold_request = 1'b0;
  logic hold_results = 1'b0;

  always #1 clk = ~clk;

  function automatic logic [15:0] bump(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] capped_sum(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic int draw_wait(int max_wait);
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, max_wait);
  endfunction

  function automatic logic [7:0] random_row();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h01 << $urandom_range(0, 7);
      3: return ~(8'h01 << $urandom_range(0, 7));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic clear_tallies();
    for (int k = 0; k < NUM_PAIRS; k++) begin
      both_seen[k]        = '0;
      first_only_seen[k]  = '0;
      second_only_seen[k] = '0;
      neither_seen[k]     = '0;
    end
  endtask

  // Count one site into every pair; on the last site queue the pair results
  task automatic tally_site(input logic [7:0] row, input logic last);
    int           k;
    int           n;
    int           emitted;
    pair_counts_t res;
    k = 0;
    for (int i = 0; i < MAX_SPECIES - 1; i++) begin
      for (int j = i + 1; j < MAX_SPECIES; j++) begin
        case ({row[i], row[j]})
          2'b11: both_seen[k] = bump(both_seen[k]);
          2'b10: first_only_seen[k] = bump(first_only_seen[k]);
          2'b01: second_only_seen[k] = bump(second_only_seen[k]);
          default: neither_seen[k] = bump(neither_seen[k]);
        endcase
        k++;
      end
    end
    if (last) begin
      n = int'(species_cfg);
      if (n < 2) n = 2;
      if (n > MAX_SPECIES) n = MAX_SPECIES;
      k = 0;
      emitted = 0;
      for (int i = 0; i < MAX_SPECIES - 1; i++) begin
        for (int j = i + 1; j < MAX_SPECIES; j++) begin
          if (j < n) begin
            res.first_species     = 4'(i + 1);
            res.second_species    = 4'(j + 1);
            res.count_first_only  = first_only_seen[k];
            res.count_second_only = second_only_seen[k];
            res.count_both        = both_seen[k];
            res.count_neither     = neither_seen[k];
            res.total_first       = capped_sum(both_seen[k], first_only_seen[k]);
            res.total_second      = capped_sum(both_seen[k], second_only_seen[k]);
            res.last_pair         = (emitted == (n * (n - 1)) / 2 - 1);
            pending_pairs.push_back(res);
            emitted++;
          end
          k++;
        end
      end
      clear_tallies();
    end
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      fail_count++;
    end
  endtask

  // Driver: offer queued sites, with a random gap after each transfer
  site_t next_site;
  int    send_gap_left;

  always @(posedge clk) begin
    if (rst) begin
      site_ch.valid        <= 1'b0;
      site_ch.presence_row <= '0;
      site_ch.last_site    <= 1'b0;
      send_gap_left        <= 0;
    end else begin
      if (site_ch.valid && site_ch.ready) begin
        tally_site(site_ch.presence_row, site_ch.last_site);
      end
      if (!site_ch.valid || site_ch.ready) begin
        if (send_gap_left != 0) begin
          site_ch.valid <= 1'b0;
          send_gap_left <= send_gap_left - 1;
        end else if (sites_to_send.size() != 0) begin
          next_site = sites_to_send.pop_front();
          site_ch.valid        <= 1'b1;
          site_ch.presence_row <= next_site.row;
          site_ch.last_site    <= next_site.last;
          send_gap_left        <= draw_wait(send_gap_max);
        end else begin
          site_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer, then stall ready at random
  pair_counts_t want_pair;
  int           recv_stall_left;
  int           next_stall;

  always @(posedge clk) begin
    if (rst) begin
      pair_ch.ready   <= 1'b0;
      recv_stall_left <= 0;
    end else begin
      next_stall = recv_stall_left;
      if (pair_ch.valid && pair_ch.ready) begin
        if (pending_pairs.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual pair %0d-%0d",
                   $time, pair_ch.first_species, pair_ch.second_species);
          fail_count++;
        end else begin
          want_pair = pending_pairs.pop_front();
          check_field("first_species", 16'(want_pair.first_species),
                      16'(pair_ch.first_species));
          check_field("second_species", 16'(want_pair.second_species),
                      16'(pair_ch.second_species));
          check_field("count_first_only", want_pair.count_first_only,
                      pair_ch.count_first_only);
          check_field("count_second_only", want_pair.count_second_only,
                      pair_ch.count_second_only);
          check_field("count_both", want_pair.count_both, pair_ch.count_both);
          check_field("count_neither", want_pair.count_neither, pair_ch.count_neither);
          check_field("total_first", want_pair.total_first, pair_ch.total_first);
          check_field("total_second", want_pair.total_second, pair_ch.total_second);
          check_field("last_pair", 16'(want_pair.last_pair), 16'(pair_ch.last_pair));
        end
        next_stall = draw_wait(recv_stall_max);
      end
      if (hold_results) begin
        pair_ch.ready <= 1'b0;
      end else if (next_stall != 0) begin
        pair_ch.ready <= 1'b0;
        next_stall = next_stall - 1;
      end else begin
        pair_ch.ready <= 1'b1;
      end
      recv_stall_left <= next_stall;
    end
  end

  // Hold off the result channel for a long stretch once requested
  initial begin
    wait (hold_request);
    @(posedge clk);
    hold_results <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_results <= 1'b0;
  end

  task automatic queue_site(input logic [7:0] row, input logic last);
    site_t s;
    s.row  = row;
    s.last = last;
    sites_to_send.push_back(s);
  endtask

  task automatic queue_data_set(input int len);
    for (int i = 0; i < len; i++) queue_site(random_row(), i == len - 1);
  endtask

  // Wait until every site is sent and every result checked, then settle
  task automatic wait_idle();
    do @(negedge clk);
    while (sites_to_send.size() != 0 || site_ch.valid || pending_pairs.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_species(input logic [CFG_BITS-1:0] v);
    wait_idle();
    @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= v;
    species_cfg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stimulus
  int phase_species [8] = '{5, 2, 8, 15, 0, 7, 3, 6};
  int gap_plan      [8] = '{14, 0, 0, 14, 6, 0, 14, 3};
  int stall_plan    [8] = '{0, 14, 0, 14, 6, 3, 14, 0};

  initial begin
    int sent;
    int len;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    species_cfg          = CFG_RESET;
    clear_tallies();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: single-site set with all present, then each pair outcome
    send_gap_max   = 3;
    recv_stall_max = 3;
    queue_site(8'hFF, 1'b1);
    queue_site(8'h00, 1'b0);
    queue_site(8'h01, 1'b0);
    queue_site(8'h80, 1'b0);
    queue_site(8'hAA, 1'b0);
    queue_site(8'h55, 1'b0);
    queue_site(8'h0F, 1'b1);
    // Unused species keep counting but are not reported
    set_species(4'd2);
    queue_site(8'hFE, 1'b0);
    queue_site(8'h03, 1'b1);
    // Species counts below the minimum act as two
    set_species(4'd0);
    queue_site(8'h02, 1'b1);
    set_species(4'd1);
    queue_site(8'h01, 1'b1);
    // Species counts above the maximum act as the maximum
    set_species(4'd15);
    queue_site(8'hF0, 1'b0);
    queue_site(8'h3C, 1'b1);
    set_species(4'd9);
    queue_site(8'h81, 1'b1);

    // Random data sets under several species settings
    for (int p = 0; p < 8; p++) begin
      set_species(4'(phase_species[p]));
      send_gap_max   = gap_plan[p];
      recv_stall_max = stall_plan[p];
      sent = 0;
      while (sent < 50) begin
        if (phase_species[p] == 8)
          len = $urandom_range(1, 2);
        else if ($urandom_range(0, 4) == 0)
          len = 1;
        else
          len = $urandom_range(2, 14);
        queue_data_set(len);
        sent += len;
      end
      // Back-to-back full sets while results are held off
      if (phase_species[p] == 8) hold_request = 1'b1;
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("pairwise_cooccurrence_counts test passed");
    end else begin
      $display("pairwise_cooccurrence_counts test failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("pairwise_cooccurrence_counts test failed");
    $finish;
  end

endmodule
